@@ src/lmpd_pkg.sv @@
// shared types and constants for the lcg minimum pair difference block
`default_nettype none

package lmpd_pkg;

    localparam int SEED_W  = 16;
    localparam int MUL_W   = 16;
    localparam int INC_W   = 16;
    localparam int MOD_W   = 16;
    localparam int COUNT_W = 9;
    localparam int GAP_W   = 16;

    localparam logic [GAP_W-1:0] GAP_MAX = {GAP_W{1'b1}};

    typedef struct packed {
        logic [SEED_W-1:0]  seed;
        logic [MUL_W-1:0]   multiplier;
        logic [INC_W-1:0]   increment;
        logic [MOD_W-1:0]   modulus;
        logic [COUNT_W-1:0] count;
    } t_in_item;

    typedef struct packed {
        logic [GAP_W-1:0] min_difference;
        logic             no_pair;
    } t_out_item;

endpackage

`default_nettype wire

@@ src/lmpd_mod_unit.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none

module lmpd_mod_unit
    import lmpd_pkg::*;
#(
    parameter int DIVIDEND_W = 33
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [MOD_W-1:0]      i_divisor,
    output logic                       o_done,
    output logic [MOD_W-1:0]           o_remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_shift;
    logic [MOD_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [MOD_W:0] trial;
    logic [MOD_W:0] trial_sub;
    logic           fits;

    // shift the next dividend bit into the partial remainder
    always_comb begin
        trial     = {r_rem, r_shift[DIVIDEND_W-1]};
        trial_sub = trial - {1'b0, i_divisor};
        fits      = (trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift << 1;
            r_rem   <= fits ? trial_sub[MOD_W-1:0] : trial[MOD_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

@@ src/lcg_min_pair_difference_core.sv @@
// top level: lcg sequence generator with minimum pairwise difference search
`default_nettype none

// One transfer on the input channel starts a request: the block builds the
// sequence seed, f(seed), f(f(seed)), ... with f(x) = (x * multiplier +
// increment) mod modulus (no reduction when modulus is zero), keeps every
// value in an internal memory, and compares each new value against all older
// ones to find the smallest absolute difference (saturated to 16 bits). A
// count below two yields no_pair = 1 and min_difference = 0. The count
// saturates to MAX_COUNT. Only one request is in flight; o_in_stall is high
// from acceptance until the result is loaded into the output register. Each
// new value passes through a multiply state, the bit-serial remainder unit
// (skipped when modulus is zero), its done strobe and a write state; the
// compare pass for value i reads the memory once per older value through its
// single read port. The output register lets the next request be accepted
// while a result waits.
module lcg_min_pair_difference_core
    import lmpd_pkg::*;
#(
    parameter int MAX_COUNT   = 256,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    localparam int VW   = VALUE_WIDTH;
    localparam int IW   = $clog2(MAX_COUNT);
    localparam int CW   = $clog2(MAX_COUNT + 1);
    localparam int XW   = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int DW   = (VW > GAP_W) ? VW : GAP_W;
    localparam int PW   = VW + MUL_W;
    localparam int NW   = PW + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       n_state;

    // request parameters held for the whole request
    logic [MUL_W-1:0] r_mul;
    logic [INC_W-1:0] r_inc;
    logic [MOD_W-1:0] r_mod;
    logic [CW-1:0]    r_cnt;

    // sequence position and current value
    logic [IW-1:0]    r_i;
    logic [VW-1:0]    r_cur;
    logic [VW-1:0]    r_new;
    logic [GAP_W-1:0] r_best;
    logic             r_no_pair;

    // compare pass: read index and registered read data
    logic [IW-1:0]    r_rd_idx;
    logic             r_rd_vld;
    logic [VW-1:0]    r_rd_data;

    // value memory
    logic [VW-1:0]    r_mem [MAX_COUNT];

    logic             r_out_valid;
    t_out_item        r_out;

    logic             accept;
    logic             out_load_ok;
    logic [XW-1:0]    count_ext;
    logic [CW-1:0]    count_sat;
    logic [DW-1:0]    seed_ext;
    logic [VW-1:0]    seed_val;
    logic [PW-1:0]    product;
    logic [NW-1:0]    dividend;
    logic             mod_done;
    logic [MOD_W-1:0] mod_rem;
    logic [DW-1:0]    rem_ext;
    logic [VW-1:0]    diff;
    logic [DW-1:0]    diff_ext;
    logic [GAP_W-1:0] gap;
    logic             last_value;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [VW-1:0]    mem_wdata;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_load_ok = !r_out_valid || !i_out_stall;

    // saturate the requested count to the memory depth
    always_comb begin
        count_ext = XW'(i_in.count);
        count_sat = (count_ext > XW'(MAX_COUNT)) ? CW'(MAX_COUNT) : CW'(count_ext);
        seed_ext  = DW'(i_in.seed);
        seed_val  = seed_ext[VW-1:0];
    end

    // generator datapath: one multiply, then the serial remainder unit
    always_comb begin
        product  = PW'(r_cur) * PW'(r_mul);
        dividend = NW'(product) + NW'(r_inc);
        rem_ext  = DW'(mod_rem);
    end

    lmpd_mod_unit #(
        .DIVIDEND_W (NW)
    ) u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     ((r_state == S_MUL) && (r_mod != '0)),
        .i_dividend  (dividend),
        .i_divisor   (r_mod),
        .o_done      (mod_done),
        .o_remainder (mod_rem)
    );

    // absolute difference against the stored value, saturated to the gap width
    always_comb begin
        diff     = (r_cur >= r_rd_data) ? (r_cur - r_rd_data) : (r_rd_data - r_cur);
        diff_ext = DW'(diff);
        gap      = (diff_ext > DW'(GAP_MAX)) ? GAP_MAX : diff_ext[GAP_W-1:0];
    end

    assign last_value = ((CW'(r_i) + CW'(1)) == r_cnt);

    // memory write port: seed at request start, new values after generation
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = r_new;
        if (accept) begin
            mem_we    = (count_sat >= CW'(2));
            mem_waddr = '0;
            mem_wdata = seed_val;
        end else if (r_state == S_WRITE) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (count_sat < CW'(2)) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                n_state = (r_mod == '0) ? S_WRITE : S_DIV;
            end
            S_DIV: begin
                if (mod_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if ((r_rd_idx == r_i) && !r_rd_vld) begin
                    n_state = last_value ? S_DONE : S_MUL;
                end
            end
            S_DONE: begin
                if (out_load_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_rd_idx    <= '0;
            r_i         <= '0;
            r_best      <= GAP_MAX;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (accept) begin
                r_best <= GAP_MAX;
                r_i    <= IW'(1);
            end

            if (r_state == S_WRITE) begin
                r_rd_idx <= '0;
            end

            // issue one read per older value, compare it in the following cycle
            if (r_state == S_CMP) begin
                if (r_rd_idx != r_i) begin
                    r_rd_vld <= 1'b1;
                    r_rd_idx <= r_rd_idx + IW'(1);
                end else begin
                    r_rd_vld <= 1'b0;
                    if (!r_rd_vld && !last_value) begin
                        r_i <= r_i + IW'(1);
                    end
                end
            end else begin
                r_rd_vld <= 1'b0;
            end

            if (r_rd_vld && (gap < r_best)) begin
                r_best <= gap;
            end

            if ((r_state == S_DONE) && out_load_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mul     <= i_in.multiplier;
            r_inc     <= i_in.increment;
            r_mod     <= i_in.modulus;
            r_cnt     <= count_sat;
            r_cur     <= seed_val;
            r_no_pair <= (count_sat < CW'(2));
        end

        // no reduction when the modulus is zero
        if ((r_state == S_MUL) && (r_mod == '0)) begin
            r_new <= dividend[VW-1:0];
        end else if ((r_state == S_DIV) && mod_done) begin
            r_new <= rem_ext[VW-1:0];
        end

        if (r_state == S_WRITE) begin
            r_cur <= r_new;
        end

        if ((r_state == S_DONE) && out_load_ok) begin
            r_out.no_pair        <= r_no_pair;
            r_out.min_difference <= r_no_pair ? '0 : r_best;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // compare reads only happen during the compare pass
    a_rd_in_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_CMP))
        else $error("compare read outside compare pass");

    // the remainder unit only finishes while the sequencer waits for it
    a_mod_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_DIV))
        else $error("remainder unit done outside divide state");

    // sequence position stays inside the requested count
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (CW'(r_i) < r_cnt))
        else $error("sequence index beyond count");

    // a no-pair result always carries a zero difference
    a_no_pair_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.no_pair) |-> (o_out.min_difference == '0))
        else $error("no-pair result with nonzero difference");

endmodule

`default_nettype wire
